// ----- rtl/ccg_pkg.sv -----
// ----------------------------------------------------------------------------
// ccg_pkg
// Shared constants and types of the clause component grouper.
// ----------------------------------------------------------------------------
`default_nettype none

package ccg_pkg;

   localparam int NUM_VARS   = 1024;
   localparam int VAR_W      = 10;
   localparam int VADDR_W    = $clog2(NUM_VARS);
   localparam int MAX_LEN    = 32;
   localparam int BUF_AW     = $clog2(MAX_LEN);
   localparam int CNT_W      = $clog2(MAX_LEN + 2);
   localparam int LABEL_BITS = 16;
   localparam int GROUP_W    = 16;
   localparam int ACTION_W   = 2;
   localparam int Q_DEPTH    = 4;
   localparam int Q_AW       = $clog2(Q_DEPTH);

   localparam logic [ACTION_W-1:0] ACT_TOGETHER = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_NEW      = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_EXTEND   = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_MERGE    = 2'd3;

   localparam logic [LABEL_BITS-1:0] LABEL_TOP = {LABEL_BITS{1'b1}};

   // one queued word: a variable of the open clause
   typedef struct packed {
      logic [VAR_W-1:0] var_index;
      logic             in_range;
      logic             last;
   } q_word_type;

endpackage

`default_nettype wire

// ----- rtl/ccg_front.sv -----
// ----------------------------------------------------------------------------
// ccg_front
// Accepts variable words, flags out-of-range indexes and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module ccg_front (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   input  wire [ccg_pkg::VAR_W-1:0]    req_var_index,
   input  wire                         req_clause_end,
   input  wire                         hold,
   input  wire                         pop,
   output logic                        busy,
   output logic                        q_valid,
   output ccg_pkg::q_word_type         q_word
);

   ccg_pkg::q_word_type q_mem [ccg_pkg::Q_DEPTH];
   logic [ccg_pkg::Q_AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [ccg_pkg::Q_AW:0]   fill_ff, fill_in;
   logic                     push, take;
   ccg_pkg::q_word_type      word_in;

   assign busy    = hold || (fill_ff == (ccg_pkg::Q_AW+1)'(ccg_pkg::Q_DEPTH));
   assign push    = start && !busy;
   assign q_valid = (fill_ff != '0);
   assign take    = pop && q_valid;
   assign q_word  = q_mem[rd_ptr_ff];

   always_comb begin
      word_in.var_index = req_var_index;
      word_in.in_range  = ({1'b0, req_var_index} < (ccg_pkg::VAR_W+1)'(ccg_pkg::NUM_VARS));
      word_in.last      = req_clause_end;
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + (ccg_pkg::Q_AW+1)'(push) - (ccg_pkg::Q_AW+1)'(take);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/ccg_back.sv -----
// ----------------------------------------------------------------------------
// ccg_back
// Buffers a clause, classifies its labels and updates the label table.
// ----------------------------------------------------------------------------
`default_nettype none

module ccg_back (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               q_valid,
   input  ccg_pkg::q_word_type               q_word,
   output logic                              pop,
   output logic                              clearing,
   output logic                              rsp_strobe,
   output logic [ccg_pkg::GROUP_W-1:0]       rsp_group_label,
   output logic [ccg_pkg::ACTION_W-1:0]      rsp_action,
   output logic                              rsp_clause_too_long,
   output logic                              rsp_labels_exhausted
);

   localparam int LB = ccg_pkg::LABEL_BITS;
   localparam int CW = ccg_pkg::CNT_W;
   localparam int AW = ccg_pkg::VADDR_W;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_COLLECT, ST_ANA_RD, ST_ANA_MEM, ST_ANA_EVAL,
      ST_DECIDE, ST_SCAN, ST_DRAIN, ST_ASG_RD, ST_ASG_WR
   } state_type;

   state_type state_ff;

   // label table: assigned bit over label
   logic [LB:0]                      var_mem [ccg_pkg::NUM_VARS];
   logic [ccg_pkg::VAR_W-1:0]        buf_mem [ccg_pkg::MAX_LEN];

   logic [CW-1:0]                    cnt_ff, n_ff, idx_ff, ntouched_ff;
   logic [LB-1:0]                    touched_ff [ccg_pkg::MAX_LEN];
   logic                             unasg_ff;
   logic [LB-1:0]                    label_ff, next_label_ff;
   logic                             exh_ff;
   logic [ccg_pkg::ACTION_W-1:0]     act_ff;
   logic                             too_long_ff, strobe_ff;
   logic [AW-1:0]                    ptr_ff, scan_addr_ff;
   logic                             scan_vld_ff;
   logic [ccg_pkg::VAR_W-1:0]        buf_q_ff;
   logic [LB:0]                      mem_q_ff;

   logic                             buf_we;
   logic [ccg_pkg::BUF_AW-1:0]       buf_wa, buf_ra;
   logic                             mem_we;
   logic [AW-1:0]                    mem_wa, mem_ra;
   logic [LB:0]                      mem_wd;
   logic                             hit;
   logic [CW-1:0]                    cnt_in;
   logic                             take;
   logic                             strobe_in;

   assign pop      = (state_ff == ST_COLLECT);
   assign take     = pop && q_valid;
   assign clearing = (state_ff == ST_CLEAR);

   always_comb begin
      hit = 1'b0;
      for (int i = 0; i < ccg_pkg::MAX_LEN; i++) begin
         if ((CW'(i) < ntouched_ff) && (touched_ff[i] == mem_q_ff[LB-1:0])) begin
            hit = 1'b1;
         end
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      buf_we = 1'b0;
      buf_wa = cnt_ff[ccg_pkg::BUF_AW-1:0];
      if (take && q_word.in_range) begin
         if (cnt_ff < CW'(ccg_pkg::MAX_LEN)) begin
            buf_we = 1'b1;
            cnt_in = cnt_ff + 1'b1;
         end else begin
            cnt_in = CW'(ccg_pkg::MAX_LEN + 1);
         end
      end
      buf_ra = idx_ff[ccg_pkg::BUF_AW-1:0];

      mem_we = 1'b0;
      mem_wa = ptr_ff;
      mem_wd = '0;
      mem_ra = ptr_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
         end
         ST_ANA_MEM: begin
            mem_ra = buf_q_ff[AW-1:0];
         end
         ST_ASG_WR: begin
            mem_we = 1'b1;
            mem_wa = buf_q_ff[AW-1:0];
            mem_wd = {1'b1, label_ff};
         end
         default: begin
         end
      endcase
      // relabel members of touched groups from the registered scan read
      if (scan_vld_ff && mem_q_ff[LB] && hit) begin
         mem_we = 1'b1;
         mem_wa = scan_addr_ff;
         mem_wd = {1'b1, label_ff};
      end
   end

   // raise the result strobe on the cycle after a clause finishes
   always_comb begin
      strobe_in = 1'b0;
      case (state_ff)
         ST_COLLECT: begin
            strobe_in = take && q_word.last &&
                        ((cnt_in > CW'(ccg_pkg::MAX_LEN)) || (cnt_in == '0));
         end
         ST_DECIDE: begin
            strobe_in = !unasg_ff && (ntouched_ff <= CW'(1));
         end
         ST_ASG_WR: begin
            strobe_in = (idx_ff == n_ff - 1'b1);
         end
         default: begin
            strobe_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[buf_wa] <= q_word.var_index;
      end
      buf_q_ff <= buf_mem[buf_ra];
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         var_mem[mem_wa] <= mem_wd;
      end
      mem_q_ff <= var_mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         cnt_ff        <= '0;
         n_ff          <= '0;
         idx_ff        <= '0;
         ntouched_ff   <= '0;
         unasg_ff      <= 1'b0;
         next_label_ff <= '0;
         exh_ff        <= 1'b0;
         ptr_ff        <= '0;
         scan_vld_ff   <= 1'b0;
         strobe_ff     <= 1'b0;
      end else begin
         strobe_ff   <= strobe_in;
         scan_vld_ff <= (state_ff == ST_SCAN);
         scan_addr_ff <= ptr_ff;
         case (state_ff)
            ST_CLEAR: begin
               ptr_ff <= ptr_ff + 1'b1;
               if (ptr_ff == AW'(ccg_pkg::NUM_VARS - 1)) begin
                  state_ff <= ST_COLLECT;
               end
            end
            ST_COLLECT: begin
               cnt_ff <= (take && q_word.last) ? '0 : cnt_in;
               if (take && q_word.last) begin
                  label_ff    <= '0;
                  act_ff      <= ccg_pkg::ACT_TOGETHER;
                  too_long_ff <= (cnt_in > CW'(ccg_pkg::MAX_LEN));
                  n_ff        <= cnt_in;
                  idx_ff      <= '0;
                  ntouched_ff <= '0;
                  unasg_ff    <= 1'b0;
                  if ((cnt_in <= CW'(ccg_pkg::MAX_LEN)) && (cnt_in != '0)) begin
                     state_ff <= ST_ANA_RD;
                  end
               end
            end
            ST_ANA_RD: begin
               state_ff <= ST_ANA_MEM;
            end
            ST_ANA_MEM: begin
               state_ff <= ST_ANA_EVAL;
            end
            ST_ANA_EVAL: begin
               if (!mem_q_ff[LB]) begin
                  unasg_ff <= 1'b1;
               end else if (!hit) begin
                  touched_ff[ntouched_ff[ccg_pkg::BUF_AW-1:0]] <= mem_q_ff[LB-1:0];
                  ntouched_ff <= ntouched_ff + 1'b1;
               end
               idx_ff <= idx_ff + 1'b1;
               state_ff <= (idx_ff == n_ff - 1'b1) ? ST_DECIDE : ST_ANA_RD;
            end
            ST_DECIDE: begin
               idx_ff <= '0;
               ptr_ff <= '0;
               if (!unasg_ff && (ntouched_ff <= CW'(1))) begin
                  label_ff  <= touched_ff[0];
                  state_ff  <= ST_COLLECT;
               end else if (ntouched_ff == CW'(1)) begin
                  label_ff <= touched_ff[0];
                  act_ff   <= ccg_pkg::ACT_EXTEND;
                  state_ff <= ST_ASG_RD;
               end else begin
                  label_ff <= next_label_ff;
                  if (next_label_ff != ccg_pkg::LABEL_TOP) begin
                     next_label_ff <= next_label_ff + 1'b1;
                  end else begin
                     exh_ff <= 1'b1;
                  end
                  if (ntouched_ff == '0) begin
                     act_ff   <= ccg_pkg::ACT_NEW;
                     state_ff <= ST_ASG_RD;
                  end else begin
                     act_ff   <= ccg_pkg::ACT_MERGE;
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               ptr_ff <= ptr_ff + 1'b1;
               if (ptr_ff == AW'(ccg_pkg::NUM_VARS - 1)) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_ASG_RD;
            end
            ST_ASG_RD: begin
               state_ff <= ST_ASG_WR;
            end
            ST_ASG_WR: begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == n_ff - 1'b1) begin
                  state_ff  <= ST_COLLECT;
               end else begin
                  state_ff <= ST_ASG_RD;
               end
            end
            default: begin
               state_ff <= ST_COLLECT;
            end
         endcase
      end
   end

   assign rsp_strobe           = strobe_ff;
   assign rsp_group_label      = label_ff[ccg_pkg::GROUP_W-1:0];
   assign rsp_action           = act_ff;
   assign rsp_clause_too_long  = too_long_ff;
   assign rsp_labels_exhausted = exh_ff;

endmodule

`default_nettype wire

// ----- rtl/clause_component_grouper_core.sv -----
// ----------------------------------------------------------------------------
// clause_component_grouper_core
// Groups variables into connected components one clause at a time.
// ----------------------------------------------------------------------------
// Variables enter one word per cycle, while busy is low, into a four-word
// queue and are buffered at one per cycle while the back end collects.
// Closing a clause looks up the label of each variable, then, unless all
// share one group, writes the label of each; a merge first scans the whole
// label table. After reset a clearing pass over the table runs with busy
// high. The result strobe lasts one cycle and cannot be held off.
`default_nettype none

module clause_component_grouper_core (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  wire [ccg_pkg::VAR_W-1:0]         req_var_index,
   input  wire                              req_clause_end,
   output logic                             rsp_strobe,
   output logic [ccg_pkg::GROUP_W-1:0]      rsp_group_label,
   output logic [ccg_pkg::ACTION_W-1:0]     rsp_action,
   output logic                             rsp_clause_too_long,
   output logic                             rsp_labels_exhausted
);

   logic                q_valid, pop, clearing;
   ccg_pkg::q_word_type q_word;

   ccg_front u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_var_index  (req_var_index),
      .req_clause_end (req_clause_end),
      .hold           (clearing),
      .pop            (pop),
      .busy           (busy),
      .q_valid        (q_valid),
      .q_word         (q_word)
   );

   ccg_back u_back (
      .clock                (clock),
      .reset                (reset),
      .q_valid              (q_valid),
      .q_word               (q_word),
      .pop                  (pop),
      .clearing             (clearing),
      .rsp_strobe           (rsp_strobe),
      .rsp_group_label      (rsp_group_label),
      .rsp_action           (rsp_action),
      .rsp_clause_too_long  (rsp_clause_too_long),
      .rsp_labels_exhausted (rsp_labels_exhausted)
   );

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

   a_too_long_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_clause_too_long) |->
         (rsp_action == ccg_pkg::ACT_TOGETHER && rsp_group_label == '0))
      else $error("ignored clause reported a grouping");

   a_busy_after_reset: assert property (@(posedge clock)
      $past(reset) |-> busy)
      else $error("input taken during table clear");

   a_exhausted_sticky: assert property (@(posedge clock) disable iff (reset)
      $past(rsp_labels_exhausted) && !$past(reset) |-> rsp_labels_exhausted)
      else $error("exhausted flag dropped");

endmodule

`default_nettype wire

// ----- tb/component_label_checker.sv -----
// ----------------------------------------------------------------------------
// component_label_checker
// Tracks the component labels of all variables from the words accepted on the
// request channel, works out the outcome of every closed clause and compares
// it field by field with each response word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module component_label_checker (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   input  wire                              busy,
   input  wire [ccg_pkg::VAR_W-1:0]         req_var_index,
   input  wire                              req_clause_end,
   input  wire                              rsp_strobe,
   input  wire [ccg_pkg::GROUP_W-1:0]       rsp_group_label,
   input  wire [ccg_pkg::ACTION_W-1:0]      rsp_action,
   input  wire                              rsp_clause_too_long,
   input  wire                              rsp_labels_exhausted,
   output int                               fail_count,
   output int                               outcomes_waiting
);

   typedef struct {
      logic [ccg_pkg::GROUP_W-1:0]  label;
      logic [ccg_pkg::ACTION_W-1:0] action;
      logic                         too_long;
      logic                         exhausted;
   } clause_outcome_type;

   logic [ccg_pkg::LABEL_BITS-1:0] group_of [ccg_pkg::NUM_VARS];
   bit                             grouped  [ccg_pkg::NUM_VARS];
   logic [ccg_pkg::VAR_W-1:0]      open_clause [$];
   int                             open_len;
   logic [ccg_pkg::LABEL_BITS-1:0] fresh_label;
   bit                             labels_used_up;
   clause_outcome_type             pending_outcomes [$];

   assign outcomes_waiting = pending_outcomes.size();

   function automatic logic [ccg_pkg::LABEL_BITS-1:0] allocate_label();
      logic [ccg_pkg::LABEL_BITS-1:0] lab;
      lab = fresh_label;
      if (fresh_label != ccg_pkg::LABEL_TOP) fresh_label = fresh_label + 1'b1;
      else labels_used_up = 1;
      return lab;
   endfunction

   function automatic clause_outcome_type group_clause();
      clause_outcome_type             res;
      logic [ccg_pkg::LABEL_BITS-1:0] touched [$];
      logic [ccg_pkg::LABEL_BITS-1:0] lab;
      bit                             all_same;
      int                             hits [$];
      res.label = '0;
      res.action = ccg_pkg::ACT_TOGETHER;
      res.too_long = 0;
      all_same = 1;
      if (open_len > ccg_pkg::MAX_LEN) begin
         res.too_long = 1;
      end else if (open_len > 0) begin
         foreach (open_clause[i]) begin
            if (!grouped[open_clause[i]]) all_same = 0;
            else begin
               hits = touched.find_index(x) with (x == group_of[open_clause[i]]);
               if (hits.size() == 0) touched = {touched, group_of[open_clause[i]]};
            end
         end
         if (touched.size() > 1) all_same = 0;
         if (all_same) begin
            res.label = touched[0];
         end else begin
            if (touched.size() == 1) begin
               lab = touched[0];
               res.action = ccg_pkg::ACT_EXTEND;
            end else begin
               lab = allocate_label();
               res.action = (touched.size() == 0) ? ccg_pkg::ACT_NEW : ccg_pkg::ACT_MERGE;
               if (touched.size() > 1)
                  for (int v = 0; v < ccg_pkg::NUM_VARS; v++) begin
                     hits = touched.find_index(x) with (x == group_of[v]);
                     if (grouped[v] && hits.size() != 0) group_of[v] = lab;
                  end
            end
            res.label = lab;
            foreach (open_clause[i])
               if (!grouped[open_clause[i]]) begin
                  grouped[open_clause[i]] = 1;
                  group_of[open_clause[i]] = lab;
               end
         end
      end
      res.exhausted = labels_used_up;
      return res;
   endfunction

   always @(posedge clock) begin
      clause_outcome_type want;
      if (reset) begin
         fail_count = 0;
         open_len = 0;
         fresh_label = '0;
         labels_used_up = 0;
         open_clause.delete();
         pending_outcomes.delete();
         foreach (grouped[i]) grouped[i] = 0;
      end else begin
         // compare first: a response never belongs to a word taken at this edge
         if (rsp_strobe) begin
            if (pending_outcomes.size() == 0) begin
               $error("response word with no clause outcome waiting");
               fail_count++;
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_group_label !== want.label) begin
                  $error("group_label expected %0d actual %0d", want.label,
                         rsp_group_label);
                  fail_count++;
               end
               if (rsp_action !== want.action) begin
                  $error("action expected %0d actual %0d", want.action, rsp_action);
                  fail_count++;
               end
               if (rsp_clause_too_long !== want.too_long) begin
                  $error("clause_too_long expected %0d actual %0d", want.too_long,
                         rsp_clause_too_long);
                  fail_count++;
               end
               if (rsp_labels_exhausted !== want.exhausted) begin
                  $error("labels_exhausted expected %0d actual %0d", want.exhausted,
                         rsp_labels_exhausted);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            // every index fits the table, so every word is buffered until the clause exceeds MAX_LEN
            if (open_len < ccg_pkg::MAX_LEN) begin
               open_clause = {open_clause, req_var_index};
               open_len++;
            end else begin
               open_len = ccg_pkg::MAX_LEN + 1;
            end
            if (req_clause_end) begin
               want = group_clause();
               pending_outcomes = {pending_outcomes, want};
               open_clause.delete();
               open_len = 0;
            end
         end
      end
   end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives clauses into the clause component grouper: a directed set covering
// new groups, extension, merging, repeats and over-long clauses, then random
// clauses drawn from narrow windows so that groups collide, under several
// sender idling phases. The checker predicts and compares each response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   localparam int WORD_TARGET  = 950;
   localparam int CYCLE_LIMIT  = 3000000;
   localparam int SETTLE_CYCLES = 1500;

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic [ccg_pkg::VAR_W-1:0]   req_var_index;
   logic                        req_clause_end;
   wire                         busy;
   wire                         rsp_strobe;
   wire [ccg_pkg::GROUP_W-1:0]  rsp_group_label;
   wire [ccg_pkg::ACTION_W-1:0] rsp_action;
   wire                         rsp_clause_too_long;
   wire                         rsp_labels_exhausted;
   int                          fail_count;
   int                          outcomes_waiting;
   int                          idle_pct;
   int                          words_sent;
   int                          cycle_count;
   logic [ccg_pkg::VAR_W-1:0]   prev_clause [$];

   clause_component_grouper_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_var_index(req_var_index), .req_clause_end(req_clause_end),
      .rsp_strobe(rsp_strobe), .rsp_group_label(rsp_group_label),
      .rsp_action(rsp_action), .rsp_clause_too_long(rsp_clause_too_long),
      .rsp_labels_exhausted(rsp_labels_exhausted)
   );

   component_label_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_var_index(req_var_index), .req_clause_end(req_clause_end),
      .rsp_strobe(rsp_strobe), .rsp_group_label(rsp_group_label),
      .rsp_action(rsp_action), .rsp_clause_too_long(rsp_clause_too_long),
      .rsp_labels_exhausted(rsp_labels_exhausted),
      .fail_count(fail_count), .outcomes_waiting(outcomes_waiting)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // hold start high across back-to-back words; drop it only for idle gaps
   task automatic send_word(input logic [ccg_pkg::VAR_W-1:0] v, input logic last);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 0;
         do @(negedge clock); while ($urandom_range(99) < idle_pct);
      end
      start <= 1;
      req_var_index <= v;
      req_clause_end <= last;
      do @(posedge clock); while (busy);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_clause(input logic [ccg_pkg::VAR_W-1:0] vars [$]);
      foreach (vars[i]) send_word(vars[i], i == vars.size() - 1);
      start <= 0;
      prev_clause = vars;
   endtask

   task automatic send_random_clause(input int win);
      logic [ccg_pkg::VAR_W-1:0] vars [$];
      int                        len;
      if (prev_clause.size() != 0 && $urandom_range(9) == 0) begin
         vars = prev_clause;
         vars.shuffle();
      end else begin
         len = ($urandom_range(32) == 0)
               ? $urandom_range(ccg_pkg::MAX_LEN + 4, ccg_pkg::MAX_LEN - 1)
               : $urandom_range(6, 1);
         repeat (len)
            if ($urandom_range(3) == 0)
               vars = {vars, ccg_pkg::VAR_W'($urandom_range(ccg_pkg::NUM_VARS - 1))};
            else
               vars = {vars, ccg_pkg::VAR_W'(win + $urandom_range(47))};
      end
      send_clause(vars);
   endtask

   initial begin
      int win;
      logic [ccg_pkg::VAR_W-1:0] vars [$];
      reset = 1;
      start = 0;
      req_var_index = '0;
      req_clause_end = 0;
      idle_pct = 0;
      words_sent = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      send_clause('{10'd0});
      send_clause('{10'd1023});
      send_clause('{10'd0, 10'd1023});
      send_clause('{10'd1023, 10'd0});
      send_clause('{10'd5, 10'd0});
      send_clause('{10'd7, 10'd7, 10'd7});
      send_clause('{10'h155, 10'h2AA});
      send_clause('{10'h2AA, 10'd7, 10'd0});
      vars.delete();
      for (int i = 0; i < ccg_pkg::MAX_LEN + 1; i++)
         vars = {vars, ccg_pkg::VAR_W'(100 + i)};
      send_clause(vars);

      for (int phase = 0; words_sent < WORD_TARGET; phase++) begin
         case (phase % 4)
            0: idle_pct = 0;
            1: idle_pct = 78;
            2: idle_pct = 35;
            default: idle_pct = $urandom_range(1) ? 78 : 0;
         endcase
         win = $urandom_range(ccg_pkg::NUM_VARS - 48);
         while (words_sent < (phase + 1) * 240 && words_sent < WORD_TARGET)
            send_random_clause(win);
      end

      start <= 0;
      wait (outcomes_waiting == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/ccg_pkg.sv
rtl/ccg_front.sv
rtl/ccg_back.sv
rtl/clause_component_grouper_core.sv
tb/component_label_checker.sv
tb/testbench.sv
